@@ design/idq_pkg.sv @@
// idq_pkg: shared types and constants for the indexed deque
// request and status codes, controller states, command and status structs
// no dependencies
package idq_pkg;

  localparam int DEPTH_DEFAULT       = 32;
  localparam int VALUE_WIDTH_DEFAULT = 16;

  // fixed port widths
  localparam int REQ_WIDTH    = 3;
  localparam int VAL_PORT_W   = 16;
  localparam int POS_WIDTH    = 5;
  localparam int STATUS_WIDTH = 2;
  localparam int LEN_WIDTH    = 6;

  typedef enum logic [REQ_WIDTH-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ       = 3'd4,
    REQ_REMOVE_AT  = 3'd5
  } req_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    push_back;
    logic    push_front;
    logic    pop_front;
    logic    pop_back;
    logic    read_issue;
    logic    remove_begin;
    logic    shift_step;
    logic    remove_finish;
    logic    load_read;
    logic    res_load;
    status_t res_status;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic in_range;
    logic shift_last;
  } dp_stat_t;

endpackage

@@ design/indexed_deque.sv @@
// indexed_deque: bounded deque with read and remove at a position
// end requests, empty/range/full answers and unused codes: done in the cycle after start, no busy
// read: busy for 1 cycle in S_READ, done registered from S_READ
// remove at p: busy through S_SHIFT and then S_FINISH, done registered from S_FINISH,
//   one entry moved per cycle through the memory's read and write port
// reset (rst, synchronous): empty deque, front slot 0; entry memory is not cleared
module indexed_deque #(
  parameter int DEPTH       = idq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = idq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [idq_pkg::REQ_WIDTH-1:0]    req_type,
  input  logic [idq_pkg::VAL_PORT_W-1:0]   item_value,
  input  logic [idq_pkg::POS_WIDTH-1:0]    position,
  output logic                             done,
  output logic [idq_pkg::VAL_PORT_W-1:0]   read_value,
  output logic [idq_pkg::STATUS_WIDTH-1:0] status,
  output logic [idq_pkg::LEN_WIDTH-1:0]    length
);
  import idq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  idq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  idq_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .item_value (item_value),
    .position   (position),
    .stat       (stat),
    .read_value (read_value),
    .status     (status),
    .length     (length),
    .done       (done)
  );

endmodule

@@ design/idq_ctrl.sv @@
// idq_ctrl: request sequencer for the indexed deque
// decodes each transaction and steps the datapath through read and remove-at
// depends on idq_pkg
module idq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [idq_pkg::REQ_WIDTH-1:0] req_type,
  input  idq_pkg::dp_stat_t             stat,
  output idq_pkg::dp_cmd_t              cmd,
  output logic                          busy
);
  import idq_pkg::*;

  state_t state;
  state_t state_next;
  req_t   req;

  assign req  = req_t'(req_type);
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && !stat.empty && stat.in_range) begin
          if (req == REQ_READ) begin
            state_next = S_READ;
          end else if (req == REQ_REMOVE_AT) begin
            state_next = S_SHIFT;
          end
        end
      end
      S_READ:   state_next = S_IDLE;
      S_SHIFT: begin
        if (stat.shift_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_status = STAT_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
              cmd.res_load = 1'b1;
              cmd.finish   = 1'b1;
              if (stat.full) begin
                cmd.res_status = STAT_FULL;
              end else if (req == REQ_PUSH_BACK) begin
                cmd.push_back = 1'b1;
              end else begin
                cmd.push_front = 1'b1;
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              cmd.res_load = 1'b1;
              cmd.finish   = 1'b1;
              if (stat.empty) begin
                cmd.res_status = STAT_EMPTY;
              end else if (req == REQ_POP_FRONT) begin
                cmd.pop_front = 1'b1;
              end else begin
                cmd.pop_back = 1'b1;
              end
            end
            REQ_READ, REQ_REMOVE_AT: begin
              if (stat.empty) begin
                cmd.res_load   = 1'b1;
                cmd.finish     = 1'b1;
                cmd.res_status = STAT_EMPTY;
              end else if (!stat.in_range) begin
                cmd.res_load   = 1'b1;
                cmd.finish     = 1'b1;
                cmd.res_status = STAT_RANGE;
              end else if (req == REQ_READ) begin
                cmd.read_issue = 1'b1;
              end else begin
                cmd.remove_begin = 1'b1;
              end
            end
            default: begin
              // unused codes: answer ok with nothing changed
              cmd.res_load = 1'b1;
              cmd.finish   = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.load_read = 1'b1;
        cmd.res_load  = 1'b1;
        cmd.finish    = 1'b1;
      end
      S_SHIFT: begin
        cmd.shift_step = !stat.shift_last;
      end
      S_FINISH: begin
        cmd.remove_finish = 1'b1;
        cmd.res_load      = 1'b1;
        cmd.finish        = 1'b1;
      end
      default: begin
        cmd.res_status = STAT_OK;
      end
    endcase
  end

endmodule

@@ design/idq_datapath.sv @@
// idq_datapath: ring buffer storage, pointers and result registers
// one write and one registered read port on the entry memory
// depends on idq_pkg
module idq_datapath #(
  parameter int DEPTH       = idq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = idq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  idq_pkg::dp_cmd_t                 cmd,
  input  logic [idq_pkg::VAL_PORT_W-1:0]   item_value,
  input  logic [idq_pkg::POS_WIDTH-1:0]    position,
  output idq_pkg::dp_stat_t                stat,
  output logic [idq_pkg::VAL_PORT_W-1:0]   read_value,
  output logic [idq_pkg::STATUS_WIDTH-1:0] status,
  output logic [idq_pkg::LEN_WIDTH-1:0]    length,
  output logic                             done
);
  import idq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data;

  logic [AW-1:0] front;
  logic [CW-1:0] count;
  logic [CW-1:0] cursor;
  logic [CW-1:0] wr_pos;
  logic          pending;

  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] cursor_inc;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic          wr_en;
  logic          rd_en;

  logic [VAL_PORT_W-1:0] read_value_q;
  status_t               status_q;

  // physical slot of a logical position, front + p stays below twice DEPTH
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] p);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(p);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  assign front_dec  = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign front_inc  = (front == AW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign pos_c      = CW'(position);
  assign cursor_inc = cursor + 1'b1;

  assign stat.empty      = (count == '0);
  assign stat.full       = (count == CW'(DEPTH));
  assign stat.in_range   = (PW'(position) < PW'(count));
  assign stat.shift_last = ((CW+1)'(cursor) + 1'b1 >= (CW+1)'(count));

  // read port: either the requested position or the next entry of a shift
  assign rd_en   = cmd.read_issue || cmd.shift_step;
  assign rd_addr = cmd.shift_step ? slot_of(front, cursor_inc) : slot_of(front, pos_c);

  // write port: pushes from idle, moved entries during a shift
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_of(front, wr_pos);
    wr_data = rd_data;
    if (cmd.push_back) begin
      wr_en   = 1'b1;
      wr_addr = slot_of(front, count);
      wr_data = VALUE_WIDTH'(item_value);
    end else if (cmd.push_front) begin
      wr_en   = 1'b1;
      wr_addr = front_dec;
      wr_data = VALUE_WIDTH'(item_value);
    end else if (pending) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front   <= '0;
      count   <= '0;
      pending <= 1'b0;
      done    <= 1'b0;
    end else begin
      done    <= cmd.finish;
      pending <= cmd.shift_step;
      if (cmd.push_back) begin
        count <= count + 1'b1;
      end else if (cmd.push_front) begin
        front <= front_dec;
        count <= count + 1'b1;
      end else if (cmd.pop_front) begin
        front <= front_inc;
        count <= count - 1'b1;
      end else if (cmd.pop_back || cmd.remove_finish) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.remove_begin) begin
      cursor <= pos_c;
    end else if (cmd.shift_step) begin
      cursor <= cursor_inc;
    end
    if (cmd.shift_step) begin
      wr_pos <= cursor;
    end
    if (cmd.res_load) begin
      status_q     <= cmd.res_status;
      read_value_q <= cmd.load_read ? VAL_PORT_W'(rd_data) : '0;
    end
  end

  assign read_value = read_value_q;
  assign status     = status_q;
  assign length     = LEN_WIDTH'(count);

endmodule
